// ----- rtl/grid_point_attractor_warp_macros.svh -----
// assertion macros for the mesh attractor warp block
`ifndef GRID_POINT_ATTRACTOR_WARP_MACROS_SVH
`define GRID_POINT_ATTRACTOR_WARP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define GPAW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GPAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gpaw_pkg.sv -----
// types and constants of the mesh attractor warp block
package gpaw_pkg;

  localparam int POS_W    = 17;
  localparam int CELL_W   = 4;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_INIT = 2'd0;
  localparam logic [OP_W-1:0] OP_WARP = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_CELLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_CELLS = 2'd1;

  localparam int ROW_CELLS_RST = 10;
  localparam int COL_CELLS_RST = 7;
  localparam int CENTRE_ROW    = 5;
  localparam int CENTRE_COL    = 4;
  localparam int CELL_SHIFT    = 5;   // cell pitch of 32
  localparam int PULL          = 100;
  localparam int PULL_W        = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CRD,
    ST_CLD,
    ST_PRD,
    ST_PLD,
    ST_SQX,
    ST_SQY,
    ST_DEC,
    ST_DIVX,
    ST_APX,
    ST_DIVY,
    ST_WR,
    ST_RRD,
    ST_RLD,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/grid_point_attractor_warp.sv -----
// mesh of points pulled toward a fixed centre point, with one shared divider
// Every item gives one result. An initialise writes all N points; a warp
// pass reads the centre point and then, for each of the N points, leaves it
// when it sits on the centre, snaps it onto the centre when it is near, or
// pulls it, where N = (row_cells+1)*(col_cells+1), at most 256. A pulled point
// uses the shared restoring divider, which gives one quotient bit per cycle,
// 17 bits for x and then 17 for y, and all points use the single port pair of
// the point memory. The point store is not cleared after reset: read only
// points that an initialise has written since the last register change.
// The input stalls while an item is at work; a finished result may wait in
// the output register while the next item is taken.
module grid_point_attractor_warp
  import gpaw_pkg::*;
#(
  parameter int MAX_CELLS = 15,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      opcode_i,
  input  logic [CELL_W-1:0]    sel_row_i,
  input  logic [CELL_W-1:0]    sel_col_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [POS_W-1:0]     pos_x_o,
  output logic [POS_W-1:0]     pos_y_o,
  output logic                 point_ok_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CELL_W-1:0]    cfg_wdata_i
);

  localparam int DEPTH  = (MAX_CELLS + 1) * (MAX_CELLS + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int D2_W   = 2 * POS_W + 1;
  localparam int REM_W  = D2_W + 1;
  localparam int M100_W = POS_W + PULL_W;
  localparam int NUM_W  = M100_W + 2 * FRAC_BITS;
  localparam int QCNT_W = $clog2(POS_W);
  localparam int INIT_W = (CELL_W + CELL_SHIFT + FRAC_BITS > POS_W) ?
                          CELL_W + CELL_SHIFT + FRAC_BITS : POS_W;
  localparam logic [D2_W-1:0] SNAP = D2_W'(PULL) << (2 * FRAC_BITS);
  localparam logic [CELL_W-1:0] MAX_C  = CELL_W'(MAX_CELLS);
  localparam logic [CELL_W-1:0] RC_RST =
    CELL_W'((ROW_CELLS_RST > MAX_CELLS) ? MAX_CELLS : ROW_CELLS_RST);
  localparam logic [CELL_W-1:0] CC_RST =
    CELL_W'((COL_CELLS_RST > MAX_CELLS) ? MAX_CELLS : COL_CELLS_RST);

  function automatic logic [CELL_W-1:0] clamp_cells(input logic [CELL_W-1:0] v,
                                                    input logic [CELL_W-1:0] lo);
    logic [CELL_W-1:0] res;
    res = v;
    if (v < lo) res = lo;
    else if (v > MAX_C) res = MAX_C;
    return res;
  endfunction

  // point (r, c) lives at r + c*(row_cells+1)
  function automatic logic [IDX_W-1:0] slot(input logic [CELL_W-1:0] r,
                                            input logic [CELL_W-1:0] c,
                                            input logic [CELL_W-1:0] rc);
    logic [9:0] s;
    s = 10'(r) + 10'(c) * (10'(rc) + 10'd1);
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] apply_pull(input logic [POS_W-1:0] p,
                                                  input logic             neg,
                                                  input logic [POS_W-1:0] q);
    return neg ? p + q : p - q;
  endfunction

  state_e state_q, state_d;

  logic [CELL_W-1:0] rc_q, rc_d, cc_q, cc_d;
  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  pos_x_q, pos_y_q;
  logic              ok_q;

  logic [IDX_W-1:0]  addr_q, addr_d;
  logic [CELL_W-1:0] r_q, r_d, c_q, c_d;
  logic [POS_W-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [POS_W-1:0]  px_q, px_d, py_q, py_d;
  logic              sx_q, sx_d, sy_q, sy_d;
  logic [POS_W-1:0]  ax_q, ax_d, ay_q, ay_d;
  logic [POS_W-1:0]  nx_q, nx_d;
  logic [2*POS_W-1:0] prod_q, prod_d;
  logic [D2_W-1:0]   d2_q, d2_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [POS_W-1:0]  num_q, num_d;
  logic [POS_W-1:0]  quo_q, quo_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0]  res_x_q, res_x_d, res_y_q, res_y_d;
  logic              res_ok_q, res_ok_d;

  logic [2*POS_W-1:0] mem_q [DEPTH];
  logic [2*POS_W-1:0] rdata_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [2*POS_W-1:0] mem_wdata;

  logic              accept, out_load, in_range, last_pt, div_last;
  logic [IDX_W-1:0]  last_addr, centre_idx;
  logic [9:0]        npts;
  logic [POS_W-1:0]  rd_x, rd_y;
  logic [POS_W-1:0]  mul_a;
  logic [2*POS_W-1:0] mul_p;
  logic [REM_W-1:0]  rem_sh, d2_ext, rem_nx;
  logic              q_bit;
  logic [POS_W-1:0]  div_mag;
  logic              div_ld;
  logic [M100_W-1:0] m100;
  logic [NUM_W-1:0]  numer;
  logic [INIT_W-1:0] init_x, init_y;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign in_range   = (sel_row_i <= rc_q) && (sel_col_i <= cc_q);
  assign npts       = (10'(rc_q) + 10'd1) * (10'(cc_q) + 10'd1) - 10'd1;
  assign last_addr  = npts[IDX_W-1:0];
  assign last_pt    = (addr_q == last_addr);
  assign centre_idx = slot(CELL_W'(CENTRE_ROW), CELL_W'(CENTRE_COL), rc_q);
  assign div_last   = (cnt_q == QCNT_W'(POS_W - 1));
  assign rd_x       = rdata_q[2*POS_W-1:POS_W];
  assign rd_y       = rdata_q[POS_W-1:0];

  // shared squarer
  assign mul_a = (state_q == ST_SQY) ? ay_q : ax_q;
  assign mul_p = (2*POS_W)'(mul_a) * (2*POS_W)'(mul_a);

  // one restoring step; the quotient is known to stay below 2^17
  assign rem_sh = {rem_q[REM_W-2:0], num_q[POS_W-1]};
  assign d2_ext = {1'b0, d2_q};
  assign q_bit  = (rem_sh >= d2_ext);
  assign rem_nx = q_bit ? rem_sh - d2_ext : rem_sh;

  assign div_mag = (state_q == ST_APX) ? ay_q : ax_q;
  assign m100    = M100_W'(div_mag) * M100_W'(PULL);
  assign numer   = NUM_W'(m100) << (2 * FRAC_BITS);

  assign init_x = INIT_W'(r_q) << (CELL_SHIFT + FRAC_BITS);
  assign init_y = INIT_W'(c_q) << (CELL_SHIFT + FRAC_BITS);

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign point_ok_o  = ok_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_INIT: state_d = ST_INIT;
            OP_WARP: state_d = ST_CRD;
            OP_READ: state_d = in_range ? ST_RRD : ST_DONE;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_INIT: if (last_pt) state_d = ST_DONE;
      ST_CRD:  state_d = ST_CLD;
      ST_CLD:  state_d = ST_PRD;
      ST_PRD:  state_d = ST_PLD;
      ST_PLD:  state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_DEC;
      ST_DEC: begin
        if (d2_q <= SNAP) state_d = last_pt ? ST_DONE : ST_PRD;
        else state_d = ST_DIVX;
      end
      ST_DIVX: if (div_last) state_d = ST_APX;
      ST_APX:  state_d = ST_DIVY;
      ST_DIVY: if (div_last) state_d = ST_WR;
      ST_WR:   state_d = last_pt ? ST_DONE : ST_PRD;
      ST_RRD:  state_d = ST_RLD;
      ST_RLD:  state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    rc_d = rc_q;  cc_d = cc_q;
    addr_d = addr_q;  r_d = r_q;  c_d = c_q;
    cx_d = cx_q;  cy_d = cy_q;  px_d = px_q;  py_d = py_q;
    sx_d = sx_q;  sy_d = sy_q;  ax_d = ax_q;  ay_d = ay_q;
    nx_d = nx_q;  prod_d = prod_q;  d2_d = d2_q;
    rem_d = rem_q;  num_d = num_q;  quo_d = quo_q;  cnt_d = cnt_q;
    res_x_d = res_x_q;  res_y_d = res_y_q;  res_ok_d = res_ok_q;
    mem_we = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = {cx_q, cy_q};
    mem_raddr = (state_q == ST_CRD) ? centre_idx : addr_q;
    div_ld = 1'b0;
    out_valid_d = out_valid_q;

    if (cfg_valid_i) begin
      case (cfg_idx_i)
        REG_ROW_CELLS: rc_d = clamp_cells(cfg_wdata_i, CELL_W'(CENTRE_ROW));
        REG_COL_CELLS: cc_d = clamp_cells(cfg_wdata_i, CELL_W'(CENTRE_COL));
        default: ;
      endcase
    end

    if (out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_d   = (opcode_i == OP_READ) ? slot(sel_row_i, sel_col_i, rc_q) : '0;
          r_d      = '0;
          c_d      = '0;
          res_x_d  = '0;
          res_y_d  = '0;
          res_ok_d = 1'b0;
        end
      end
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {init_x[POS_W-1:0], init_y[POS_W-1:0]};
        addr_d    = addr_q + IDX_W'(1);
        if (r_q == rc_q) begin
          r_d = '0;
          c_d = c_q + CELL_W'(1);
        end else begin
          r_d = r_q + CELL_W'(1);
        end
      end
      ST_CLD: begin
        cx_d = rd_x;
        cy_d = rd_y;
      end
      ST_PLD: begin
        px_d = rd_x;
        py_d = rd_y;
        sx_d = (rd_x < cx_q);
        sy_d = (rd_y < cy_q);
        ax_d = (rd_x < cx_q) ? cx_q - rd_x : rd_x - cx_q;
        ay_d = (rd_y < cy_q) ? cy_q - rd_y : rd_y - cy_q;
      end
      ST_SQX: prod_d = mul_p;
      ST_SQY: d2_d = D2_W'(prod_q) + D2_W'(mul_p);
      ST_DEC: begin
        if (d2_q <= SNAP) begin
          // a point on the centre stays, a near one snaps onto it
          mem_we = (d2_q != '0);
          addr_d = addr_q + IDX_W'(1);
        end else begin
          div_ld = 1'b1;
        end
      end
      ST_DIVX, ST_DIVY: begin
        rem_d = rem_nx;
        num_d = {num_q[POS_W-2:0], 1'b0};
        quo_d = {quo_q[POS_W-2:0], q_bit};
        cnt_d = cnt_q + QCNT_W'(1);
      end
      ST_APX: begin
        nx_d   = apply_pull(px_q, sx_q, quo_q);
        div_ld = 1'b1;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {nx_q, apply_pull(py_q, sy_q, quo_q)};
        addr_d    = addr_q + IDX_W'(1);
      end
      ST_RLD: begin
        res_x_d  = rd_x;
        res_y_d  = rd_y;
        res_ok_d = 1'b1;
      end
      default: ;
    endcase

    if (div_ld) begin
      rem_d = REM_W'(numer[NUM_W-1:POS_W]);
      num_d = numer[POS_W-1:0];
      quo_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rc_q        <= RC_RST;
      cc_q        <= CC_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rc_q        <= rc_d;
      cc_q        <= cc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;  r_q <= r_d;  c_q <= c_d;
    cx_q <= cx_d;  cy_q <= cy_d;  px_q <= px_d;  py_q <= py_d;
    sx_q <= sx_d;  sy_q <= sy_d;  ax_q <= ax_d;  ay_q <= ay_d;
    nx_q <= nx_d;  prod_q <= prod_d;  d2_q <= d2_d;
    rem_q <= rem_d;  num_q <= num_d;  quo_q <= quo_d;  cnt_q <= cnt_d;
    res_x_q <= res_x_d;  res_y_q <= res_y_d;  res_ok_q <= res_ok_d;
    if (out_load) begin
      pos_x_q <= res_x_q;
      pos_y_q <= res_y_q;
      ok_q    <= res_ok_q;
    end
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[mem_raddr];
  end

  `include "grid_point_attractor_warp_macros.svh"

  `GPAW_ASSERT_NOW(a_div_rem_below_d2, (state_q == ST_DIVX || state_q == ST_DIVY), (rem_q < d2_ext), "divider remainder not below d2")
  `GPAW_ASSERT_NOW(a_pull_below_mag, (state_q == ST_APX), (quo_q < ax_q || ax_q == '0), "pull quotient not below distance")
  `GPAW_ASSERT_NEXT(a_done_gives_result, (state_q == ST_DONE && out_load), out_valid_q, "finished item gave no result")

endmodule
